// ===== rtl/core/idpm_pkg.sv =====
`timescale 1ns / 1ps
package idpm_pkg;

  // Register indexes of the configuration port
  localparam logic [2:0] CFG_TERM_COUNT = 3'd0;
  localparam logic [2:0] CFG_COEF_ZERO  = 3'd1;
  localparam logic [2:0] CFG_COEF_ONE   = 3'd2;
  localparam logic [2:0] CFG_COEF_TWO   = 3'd3;
  localparam logic [2:0] CFG_COEF_THREE = 3'd4;

  localparam int unsigned MAX_TERMS = 4;
  localparam int unsigned DEPTH_W   = 20;
  localparam int unsigned QUOT_W    = 32;
  localparam logic [2:0]  MAX_TERMS_C = 3'(MAX_TERMS);
  localparam logic [31:0] ONE_Q16   = 32'h0001_0000;

  // One item in flight through the reciprocal chain
  typedef struct packed {
    logic                 valid;
    logic                 one;
    logic [DEPTH_W-1:0]   d;
    logic [DEPTH_W-1:0]   rem;
    logic [QUOT_W-1:0]    q;
  } div_t;

  // One item in flight through the polynomial chain
  typedef struct packed {
    logic               valid;
    logic               r_clamped;
    logic               sat;
    logic [31:0]        r;
    logic [31:0]        p;
    logic signed [31:0] acc;
  } poly_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } clamp_t;

  // Clamp a wide signed value to the 32-bit range, flagging a clamp
  function automatic clamp_t clamp32(input logic signed [64:0] v);
    clamp_t res;
    res.sat = 1'b0;
    res.val = v[31:0];
    if (v > 65'sd2147483647) begin
      res.sat = 1'b1;
      res.val = 32'sh7FFF_FFFF;
    end else if (v < -65'sd2147483648) begin
      res.sat = 1'b1;
      res.val = 32'sh8000_0000;
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/idpm_div_cell.sv =====
`timescale 1ns / 1ps
module idpm_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [4:0]      bit_i,
  input  idpm_pkg::div_t  in_i,
  output idpm_pkg::div_t  out_o
);
  import idpm_pkg::*;

  logic [DEPTH_W:0] rem2;
  div_t             cell_d, cell_q;

  // Shift in a zero bit of the dividend and try to subtract the divisor
  always_comb begin
    rem2   = {in_i.rem, 1'b0};
    cell_d = in_i;
    if (rem2 >= {1'b0, in_i.d}) begin
      rem2 = rem2 - {1'b0, in_i.d};
      cell_d.q[bit_i] = 1'b1;
    end
    cell_d.rem = rem2[DEPTH_W-1:0];
  end

  // Advance on enable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign out_o = cell_q;
endmodule

// ===== rtl/core/idpm_term_cell.sv =====
`timescale 1ns / 1ps
module idpm_term_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [2:0]         idx_i,
  input  logic [2:0]         n_i,
  input  logic signed [31:0] coef_i,
  input  idpm_pkg::poly_t    in_i,
  output idpm_pkg::poly_t    out_o
);
  import idpm_pkg::*;

  logic signed [32:0] p_s;
  logic signed [64:0] prod_d, prod_q;
  logic [63:0]        np_d, np_q;
  logic               used_d, used_q;
  poly_t              a_q, b_d, b_q;
  logic signed [64:0] term_w, sum_w;
  clamp_t             term_c, sum_c;
  logic               last;

  // Stage A: both multiplications
  always_comb begin
    p_s    = {1'b0, in_i.p};
    prod_d = 65'(coef_i) * 65'(p_s);
    np_d   = 64'(in_i.p) * 64'(in_i.r);
    used_d = idx_i < n_i;
  end

  // Advance both stages on enable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
    end else if (en_i) begin
      a_q <= in_i;
      b_q <= b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      np_q   <= np_d;
      used_q <= used_d;
    end
  end

  // Stage B: scale, clamp, accumulate and form the next power
  always_comb begin
    term_w = prod_q >>> 16;
    term_c = clamp32(term_w);
    sum_w  = 65'(a_q.acc) + 65'(term_c.val);
    sum_c  = clamp32(sum_w);
    last   = (4'(idx_i) + 4'd1) >= 4'(n_i);
    b_d    = a_q;
    if (used_q) begin
      b_d.acc = sum_c.val;
      b_d.sat = a_q.sat | term_c.sat | sum_c.sat
              | ((idx_i == 3'd1) & a_q.r_clamped);
      if (np_q[63:48] != 16'd0) begin
        b_d.p = 32'hFFFF_FFFF;
        if (!last && idx_i != 3'd0) begin
          b_d.sat = 1'b1;
        end
      end else begin
        b_d.p = np_q[47:16];
      end
    end
  end

  assign out_o = b_q;
endmodule

// ===== rtl/core/inverse_depth_polynomial_map.sv =====
`timescale 1ns / 1ps
// Inverse-depth polynomial map. Each depth sample (unsigned Q4.16, zero taken
// as one LSB) is turned into its Q16.16 reciprocal by a chain of 32 restoring
// division cells, one quotient bit per cell, and then run through four term
// cells, each two stages deep, that multiply, clamp and accumulate one
// polynomial term. One sample is taken every clock unless the chain holds;
// its result passes through 32 division stages and then eight term stages,
// and the whole chain holds while a result waits. Write configuration only
// while no samples are in flight.
module inverse_depth_polynomial_map (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [19:0]  depth_sample_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [31:0]  distance_o,
  output logic         saturated_o
);
  import idpm_pkg::*;

  logic [2:0]         term_count_q;
  logic signed [31:0] coef_q [MAX_TERMS];
  logic [2:0]         n;
  logic               en;
  div_t               div_in;
  div_t               div_s [QUOT_W+1];
  poly_t              poly_in;
  poly_t              poly_s [MAX_TERMS+1];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= 3'd1;
      for (int i = 0; i < MAX_TERMS; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TERM_COUNT: term_count_q <= cfg_data_i[2:0];
        CFG_COEF_ZERO:  coef_q[0]    <= cfg_data_i;
        CFG_COEF_ONE:   coef_q[1]    <= cfg_data_i;
        CFG_COEF_TWO:   coef_q[2]    <= cfg_data_i;
        CFG_COEF_THREE: coef_q[3]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign n = (term_count_q > MAX_TERMS_C) ? MAX_TERMS_C : term_count_q;

  // Advance the whole chain unless a finished result is held
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Seed the division: the dividend's leading one is already in the remainder
  always_comb begin
    div_in.valid = in_valid_i;
    div_in.d     = (depth_sample_i == '0) ? DEPTH_W'(1) : depth_sample_i;
    div_in.one   = (depth_sample_i == '0) || (depth_sample_i == DEPTH_W'(1));
    div_in.rem   = DEPTH_W'(1);
    div_in.q     = '0;
  end
  assign div_s[0] = div_in;

  for (genvar k = 0; k < QUOT_W; k++) begin : g_div
    idpm_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .bit_i  (5'(QUOT_W - 1 - k)),
      .in_i   (div_s[k]),
      .out_o  (div_s[k+1])
    );
  end

  // Hand the reciprocal to the term cells, clamped for a one-LSB depth
  always_comb begin
    poly_in.valid     = div_s[QUOT_W].valid;
    poly_in.r_clamped = div_s[QUOT_W].one;
    poly_in.r         = div_s[QUOT_W].one ? 32'hFFFF_FFFF : div_s[QUOT_W].q;
    poly_in.p         = ONE_Q16;
    poly_in.acc       = '0;
    poly_in.sat       = 1'b0;
  end
  assign poly_s[0] = poly_in;

  for (genvar t = 0; t < MAX_TERMS; t++) begin : g_term
    idpm_term_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .idx_i  (3'(t)),
      .n_i    (n),
      .coef_i (coef_q[t]),
      .in_i   (poly_s[t]),
      .out_o  (poly_s[t+1])
    );
  end

  assign out_valid_o = poly_s[MAX_TERMS].valid;
  assign distance_o  = poly_s[MAX_TERMS].acc;
  assign saturated_o = poly_s[MAX_TERMS].sat;

endmodule

// ===== rtl/core/idpm_checker.sv =====
`timescale 1ns / 1ps
module idpm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] distance_o,
  input logic        saturated_o
);
  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_o)
      && $stable(saturated_o))
    else $error("stalled result changed");

  // A held result stalls the input side
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result held");

  // With nothing to deliver the block takes input
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input refused while output empty");
endmodule

bind inverse_depth_polynomial_map idpm_checker u_idpm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .distance_o  (distance_o),
  .saturated_o (saturated_o)
);
